>>> design/ptd_pkg.sv
// Package for the periodic task dispatcher: request codes, widths, types.
// No dependencies.
package ptd_pkg;
  localparam int SlotsDefault = 16;
  localparam int IdW = 16;
  localparam int PerW = 16;
  localparam int DueW = 32;
  localparam int CntW = 5;

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_TICK   = 3'd2;
  localparam logic [2:0] REQ_DONE   = 3'd3;
  localparam logic [2:0] REQ_START  = 3'd4;
  localparam logic [2:0] REQ_PAUSE  = 3'd5;
  localparam logic [2:0] REQ_CLEAR  = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic act;       // perform request action
    logic scan_clr;  // restart scan
    logic scan_step; // examine one slot
    logic fin;       // end check and result
    logic pop;       // result taken
  } ptd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } ptd_sts_t;
endpackage

>>> design/ptd_dp.sv
// Datapath: slot table, timing state, slot scan and result register.
// Depends on ptd_pkg.
module ptd_dp import ptd_pkg::*; #(
  parameter int SLOTS = SlotsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptd_cmd_t          cmd,
  output ptd_sts_t          sts,
  input  logic [2:0]        in_req_type,
  input  logic [PerW-1:0]   in_period,
  input  logic [IdW-1:0]    in_target_id,
  input  logic              in_keep_task,
  output logic              out_ok,
  output logic [IdW-1:0]    out_new_id,
  output logic              out_fire_valid,
  output logic [IdW-1:0]    out_fire_id,
  output logic              out_stopped,
  output logic [CntW-1:0]   out_tasks_left,
  output logic              out_is_running
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW = $clog2(SLOTS + 1);

  logic [SLOTS-1:0] valid_r;
  logic [IdW-1:0]   id_mem  [SLOTS];
  logic [PerW-1:0]  per_mem [SLOTS];
  logic [DueW-1:0]  due_mem [SLOTS];

  logic [2:0] req_r;
  logic [PerW-1:0] per_r;
  logic [IdW-1:0] tid_r;
  logic keep_r;

  logic [DueW-1:0] elapsed_r;
  logic run_r, pause_r, exv_r, busy_r;
  logic [IdW-1:0] exid_r, idc_r;
  logic [PerW-1:0] exper_r;

  // scan state
  logic [SW-1:0] idx_r;
  logic free_f_r, idm_f_r, best_f_r;
  logic [SW-1:0] free_r, idm_r, best_r;
  logic [DueW-1:0] best_due_r;
  logic [NW-1:0] cnt_r;

  logic ok_r, fire_r, stop_r;
  logic [IdW-1:0] nid_r, fid_r;

  assign sts.scan_last = (idx_r == SW'(SLOTS - 1));

  function automatic logic [DueW-1:0] due_of(input logic run, input logic [DueW-1:0] el,
                                             input logic [PerW-1:0] p);
    logic [DueW-1:0] b;
    logic [DueW:0] s;
    b = run ? el : '0;
    s = {1'b0, b} + {{(DueW+1-PerW){1'b0}}, p};
    return s[DueW] ? '1 : s[DueW-1:0];
  endfunction

  logic cur_v;
  assign cur_v = valid_r[idx_r];

  logic add_ok;
  assign add_ok = (per_r != '0) && free_f_r;

  logic fire_c, stop_c;
  always_comb begin
    stop_c = run_r && !busy_r && (pause_r || cnt_r == '0);
    fire_c = run_r && !busy_r && !stop_c && best_f_r && best_due_r <= elapsed_r;
  end

  // result flags of the action step
  logic act_ok;
  logic [IdW-1:0] act_nid;
  always_comb begin
    act_ok = 1'b0;
    act_nid = '0;
    case (req_r)
      REQ_ADD: if (add_ok) begin
        act_ok = 1'b1;
        act_nid = idc_r;
      end
      REQ_REMOVE: act_ok = (tid_r != '0) && ((busy_r && exv_r && exid_r == tid_r) || idm_f_r);
      REQ_TICK: act_ok = 1'b1;
      REQ_DONE: act_ok = busy_r;
      REQ_START: act_ok = !run_r;
      REQ_PAUSE: act_ok = 1'b1;
      REQ_CLEAR: act_ok = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      per_r  <= in_period;
      tid_r  <= in_target_id;
      keep_r <= in_keep_task;
    end
    if (cmd.scan_step) begin
      if (cur_v && (!best_f_r || due_mem[idx_r] < best_due_r)) begin
        best_r <= idx_r;
        best_due_r <= due_mem[idx_r];
      end
      if (!cur_v && !free_f_r) free_r <= idx_r;
      if (cur_v && id_mem[idx_r] == tid_r && !idm_f_r) idm_r <= idx_r;
    end
    if (cmd.act && req_r == REQ_ADD && add_ok) begin
      id_mem[free_r]  <= idc_r;
      per_mem[free_r] <= per_r;
      due_mem[free_r] <= due_of(run_r, elapsed_r, per_r);
    end
    if (cmd.act && req_r == REQ_DONE && busy_r && keep_r && exv_r && free_f_r) begin
      id_mem[free_r]  <= exid_r;
      per_mem[free_r] <= exper_r;
      due_mem[free_r] <= due_of(run_r, elapsed_r, exper_r);
    end
    // latch the dispatched task only; hold the executing one otherwise
    if (cmd.fin && fire_c) begin
      exid_r  <= id_mem[best_r];
      exper_r <= per_mem[best_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; elapsed_r <= '0; run_r <= 1'b0; pause_r <= 1'b0;
      exv_r <= 1'b0; busy_r <= 1'b0; idc_r <= IdW'(1);
      idx_r <= '0; free_f_r <= 1'b0; idm_f_r <= 1'b0; best_f_r <= 1'b0;
      cnt_r <= '0; ok_r <= 1'b0; fire_r <= 1'b0; stop_r <= 1'b0;
      nid_r <= '0; fid_r <= '0;
    end else begin
      if (cmd.scan_clr) begin
        idx_r <= '0; free_f_r <= 1'b0; idm_f_r <= 1'b0; best_f_r <= 1'b0;
        cnt_r <= '0;
      end
      if (cmd.scan_step) begin
        if (!sts.scan_last) idx_r <= idx_r + SW'(1);
        if (cur_v) begin
          cnt_r <= cnt_r + NW'(1);
          best_f_r <= 1'b1;
          if (id_mem[idx_r] == tid_r) idm_f_r <= 1'b1;
        end else begin
          free_f_r <= 1'b1;
        end
      end
      if (cmd.act) begin
        ok_r <= act_ok;
        nid_r <= act_nid;
        unique case (req_r)
          REQ_ADD: if (add_ok) begin
            valid_r[free_r] <= 1'b1;
            idc_r <= (idc_r == '1) ? IdW'(1) : idc_r + IdW'(1);
          end
          REQ_REMOVE: if (tid_r != '0) begin
            if (busy_r && exv_r && exid_r == tid_r) begin
              exv_r <= 1'b0;
            end else if (idm_f_r) begin
              valid_r[idm_r] <= 1'b0;
            end
          end
          REQ_TICK: begin
            if (run_r && elapsed_r != '1) elapsed_r <= elapsed_r + DueW'(1);
          end
          REQ_DONE: if (busy_r) begin
            if (keep_r && exv_r && free_f_r) valid_r[free_r] <= 1'b1;
            busy_r <= 1'b0; exv_r <= 1'b0;
          end
          REQ_START: if (!run_r) begin
            run_r <= 1'b1; elapsed_r <= '0; pause_r <= 1'b0;
          end
          REQ_PAUSE: begin
            if (run_r) pause_r <= 1'b1;
          end
          REQ_CLEAR: begin
            valid_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.fin) begin
        stop_r <= stop_c;
        fire_r <= fire_c;
        fid_r  <= fire_c ? id_mem[best_r] : '0;
        if (stop_c) begin
          run_r <= 1'b0; pause_r <= 1'b0;
        end
        if (fire_c) begin
          valid_r[best_r] <= 1'b0;
          busy_r <= 1'b1; exv_r <= 1'b1;
        end
        cnt_r <= cnt_r - NW'(fire_c);
      end
    end
  end

  assign out_ok = ok_r;
  assign out_new_id = nid_r;
  assign out_fire_valid = fire_r;
  assign out_fire_id = fid_r;
  assign out_stopped = stop_r;
  assign out_tasks_left = CntW'(cnt_r);
  assign out_is_running = run_r;
endmodule

>>> design/ptd_ctrl.sv
// Controller: sequences load, pre-scan, action, end-check scan and output.
// Depends on ptd_pkg.
module ptd_ctrl import ptd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ptd_sts_t sts,
  output ptd_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN1 = 3'd1;
  localparam logic [2:0] S_ACT = 3'd2;
  localparam logic [2:0] S_SCAN2 = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] st_r, st_nxt;

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);

  always_comb begin
    cmd = '0;
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; cmd.scan_clr = 1'b1; st_nxt = S_SCAN1;
      end
      S_SCAN1: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) st_nxt = S_ACT;
      end
      S_ACT: begin
        cmd.act = 1'b1; cmd.scan_clr = 1'b1; st_nxt = S_SCAN2;
      end
      S_SCAN2: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) st_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1; st_nxt = S_OUT;
      end
      S_OUT: if (out_ready) begin
        cmd.pop = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end
endmodule

>>> design/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher.
// Depends on ptd_pkg, ptd_ctrl, ptd_dp.
// One request at a time: its result appears after two one-slot-per-cycle scans
// of the table (a pre-scan for free slot and id match, then a scan for count
// and earliest due task after the action) plus an action step and an
// end-check step. The result holds until out_ready; a new request is accepted
// only once the result has been taken and the controller is idle again.
module periodic_task_dispatcher import ptd_pkg::*; #(
  parameter int SLOTS = SlotsDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_req_type,
  input  logic [PerW-1:0] in_period,
  input  logic [IdW-1:0]  in_target_id,
  input  logic            in_keep_task,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_ok,
  output logic [IdW-1:0]  out_new_id,
  output logic            out_fire_valid,
  output logic [IdW-1:0]  out_fire_id,
  output logic            out_stopped,
  output logic [CntW-1:0] out_tasks_left,
  output logic            out_is_running
);
  ptd_cmd_t cmd;
  ptd_sts_t sts;

  // sequence each request through the scans
  ptd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  // hold the table and produce the result
  ptd_dp #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_req_type, .in_period, .in_target_id, .in_keep_task,
    .out_ok, .out_new_id, .out_fire_valid, .out_fire_id, .out_stopped,
    .out_tasks_left, .out_is_running
  );

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_fire_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fire_valid |-> out_fire_id == '0) else $error("stray fire id");
  a_fire_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_fire_valid && out_stopped)) else $error("fire and stop");
`endif
endmodule
